/* hdl/fbik_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_pkg
// Shared types, widths, micro-op codes and small functions of the five-bar
// inverse kinematics solver.
// ----------------------------------------------------------------------------
package fbik_pkg;

  localparam int CoordW    = 16;
  localparam int CfgW      = 15;
  localparam int CfgIdxW   = 2;
  localparam int AngW      = 16;
  localparam int AngleFracBits = 12;
  localparam int WorkBits  = 20;
  localparam int AngShift  = WorkBits - AngleFracBits;
  localparam int OffW      = 18;
  localparam int MulW      = 34;
  localparam int ProdW     = 2 * MulW;
  localparam int KneeW     = 52;
  localparam int RootW     = 64;
  localparam int HgtW      = 32;
  localparam int CorW      = 53;
  localparam int ZW        = 24;
  localparam int AngWideW  = 26;
  localparam int CordicSteps = 20;
  localparam int StepW     = 5;
  localparam int TabW      = 20;

  localparam logic signed [ZW-1:0] PiWork = 24'sd3294199;

  localparam logic [StepW-1:0] StepSpan = 5'd13;
  localparam logic [StepW-1:0] StepSqrt = 5'd17;
  localparam logic [StepW-1:0] StepLast = 5'd26;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE  = 2'd0,
    REG_UPPER = 2'd1,
    REG_LOWER = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD_IN, OP_OFFSET,
    OP_MUL_OXOX, OP_D2_LOAD, OP_MUL_OYOY, OP_D2_ADD,
    OP_MUL_UPUP, OP_UP2_LOAD, OP_MUL_LOLO, OP_LO2_LOAD,
    OP_MUL_SUM, OP_SUM2_LOAD, OP_MUL_GAP, OP_CHECK,
    OP_MUL_SPAN, OP_SPAN_LOAD, OP_MUL_LEAD2, OP_RAD, OP_SQRT_START,
    OP_MUL_LEADOX, OP_PA_LOAD, OP_MUL_HOY, OP_U_SET,
    OP_MUL_LEADOY, OP_MUL_HOX, OP_V_SET, OP_PICK,
    OP_ATAN_START, OP_ANG_STORE, OP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   left;
  } dp_cmd_t;

  typedef struct packed {
    logic reach;
    logic sqrt_done;
    logic atan_done;
    logic out_busy;
  } dp_sts_t;

  // micro-op sequence of one knee solve
  function automatic dp_op_e knee_op(logic [StepW-1:0] step);
    dp_op_e op;
    case (step)
      5'd0:  op = OP_OFFSET;
      5'd1:  op = OP_MUL_OXOX;
      5'd2:  op = OP_D2_LOAD;
      5'd3:  op = OP_MUL_OYOY;
      5'd4:  op = OP_D2_ADD;
      5'd5:  op = OP_MUL_UPUP;
      5'd6:  op = OP_UP2_LOAD;
      5'd7:  op = OP_MUL_LOLO;
      5'd8:  op = OP_LO2_LOAD;
      5'd9:  op = OP_MUL_SUM;
      5'd10: op = OP_SUM2_LOAD;
      5'd11: op = OP_MUL_GAP;
      5'd12: op = OP_CHECK;
      5'd13: op = OP_MUL_SPAN;
      5'd14: op = OP_SPAN_LOAD;
      5'd15: op = OP_MUL_LEAD2;
      5'd16: op = OP_RAD;
      5'd17: op = OP_SQRT_START;
      5'd18: op = OP_MUL_LEADOX;
      5'd19: op = OP_PA_LOAD;
      5'd20: op = OP_MUL_HOY;
      5'd21: op = OP_U_SET;
      5'd22: op = OP_MUL_LEADOY;
      5'd23: op = OP_PA_LOAD;
      5'd24: op = OP_MUL_HOX;
      5'd25: op = OP_V_SET;
      5'd26: op = OP_PICK;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

  // atan(2^-i) in q.20 radians
  function automatic logic [TabW-1:0] atan_entry(logic [StepW-1:0] i);
    logic [TabW-1:0] v;
    case (i)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // arithmetic shift right that truncates toward zero
  function automatic logic signed [CorW-1:0] shr_tz(logic signed [CorW-1:0] v,
                                                   logic [StepW-1:0] s);
    logic [CorW-1:0] m;
    m = v[CorW-1] ? CorW'(-v) : CorW'(v);
    m = m >> s;
    return v[CorW-1] ? $signed(-m) : $signed(m);
  endfunction

  // round half up to the angle format and saturate
  function automatic logic signed [AngW-1:0] to_angle(logic signed [AngWideW-1:0] w);
    logic signed [AngWideW:0] t;
    logic signed [AngWideW:0] q;
    t = (AngWideW+1)'(w) + ((AngWideW+1)'(1) <<< (AngShift - 1));
    q = t >>> AngShift;
    if (q > (AngWideW+1)'(32767)) return 16'sh7fff;
    else if (q < -(AngWideW+1)'(32768)) return 16'sh8000;
    else return q[AngW-1:0];
  endfunction

endpackage

/* hdl/five_bar_inverse_kinematics_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics_top
// Five-bar leg inverse kinematics: foot position in, motor angles out.
// ----------------------------------------------------------------------------
// One foot position (signed q7.8) is solved at a time. Each of the two knees
// takes 27 micro-op steps around the shared 34x34 multiplier and a wait on
// the iterative square root. Each motor angle then goes through the atan
// unit: a normalization that moves one bit a cycle, followed by twenty
// vectoring steps; a zero knee vector skips both. A foot out of reach of
// either pivot finishes after the first failing check and reports
// reachable = 0 with the last good angles. A new item is taken once the
// previous result has been moved to the output register. Link lengths are
// to be written on the cfg port only while the block is idle; the block
// itself does not enforce this.
module five_bar_inverse_kinematics_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // foot_x, foot_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // right_angle, left_angle
  output logic [0:0]  m_axis_tuser,   // reachable
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import fbik_pkg::*;

  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic                   reachable;
  logic signed [AngW-1:0] right_angle, left_angle;

  fbik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fbik_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .foot_x_i      ($signed(s_axis_tdata[15:0])),
    .foot_y_i      ($signed(s_axis_tdata[31:16])),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .reachable_o   (reachable),
    .right_angle_o (right_angle),
    .left_angle_o  (left_angle)
  );

  assign m_axis_tdata = {left_angle, right_angle};
  assign m_axis_tuser = reachable;

endmodule

/* hdl/fbik_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_isqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module fbik_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbik_pkg::RootW-1:0]  rad_i,
  output logic [fbik_pkg::HgtW-1:0]   root_o,
  output logic                        done_o
);
  import fbik_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RootW-1:0] n_q, n_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RootW-1:0] bit_q, bit_d;
  logic [RootW-1:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    n_d    = n_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      n_d    = rad_i;
      root_d = '0;
      bit_d  = RootW'(1) << (RootW - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d    = n_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign root_o = root_q[HgtW-1:0];
  assign done_o = done_q;

endmodule

/* hdl/fbik_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_cordic
// atan2 in q.20 radians: half-plane turn, one-bit-a-cycle normalization, then
// twenty vectoring iterations.
// ----------------------------------------------------------------------------
module fbik_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fbik_pkg::KneeW-1:0] x_i,
  input  logic signed [fbik_pkg::KneeW-1:0] y_i,
  output logic signed [fbik_pkg::ZW-1:0]    z_o,
  output logic                              done_o
);
  import fbik_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_NORM = 3'b010,
    CS_ITER = 3'b100
  } cor_state_e;

  localparam logic [CorW-1:0] MagHigh = CorW'(1) << 30;
  localparam logic [CorW-1:0] MagLow  = CorW'(1) << 29;

  cor_state_e              state_q, state_d;
  logic                    done_q, done_d;
  logic signed [CorW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]    z_q, z_d, turn_q, turn_d;
  logic [StepW-1:0]        i_q, i_d;
  logic signed [CorW-1:0]  xe, ye, sx, sy;
  logic [CorW-1:0]         ax, ay, mag;
  logic signed [ZW-1:0]    tab;

  assign xe  = CorW'(x_i);
  assign ye  = CorW'(y_i);
  assign ax  = x_q[CorW-1] ? CorW'(-x_q) : CorW'(x_q);
  assign ay  = y_q[CorW-1] ? CorW'(-y_q) : CorW'(y_q);
  assign mag = (ax > ay) ? ax : ay;
  assign sx  = shr_tz(y_q, i_q);
  assign sy  = shr_tz(x_q, i_q);
  assign tab = $signed({{(ZW-TabW){1'b0}}, atan_entry(i_q)});

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    turn_d  = turn_q;
    i_d     = i_q;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          z_d = '0;
          i_d = '0;
          if (xe == '0 && ye == '0) begin
            turn_d = '0;
            done_d = 1'b1;
          end else begin
            state_d = CS_NORM;
            if (xe < 0) begin
              turn_d = (ye >= 0) ? PiWork : -PiWork;
              x_d    = -xe;
              y_d    = -ye;
            end else begin
              turn_d = '0;
              x_d    = xe;
              y_d    = ye;
            end
          end
        end
      end
      CS_NORM: begin
        if (mag >= MagHigh) begin
          x_d = shr_tz(x_q, StepW'(1));
          y_d = shr_tz(y_q, StepW'(1));
        end else if (mag < MagLow) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          state_d = CS_ITER;
        end
      end
      CS_ITER: begin
        if (y_q > 0) begin
          x_d = x_q + sx;
          y_d = y_q - sy;
          z_d = z_q + tab;
        end else begin
          x_d = x_q - sx;
          y_d = y_q + sy;
          z_d = z_q - tab;
        end
        i_d = i_q + StepW'(1);
        if (i_q == StepW'(CordicSteps - 1)) begin
          state_d = CS_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    turn_q <= turn_d;
    i_q    <= i_d;
  end

  assign z_o    = z_q + turn_q;
  assign done_o = done_q;

endmodule

/* hdl/fbik_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_dp
// Datapath: link registers, shared multiplier, circle-intersection registers,
// square root and atan units, held angles and the output register.
// ----------------------------------------------------------------------------
module fbik_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbik_pkg::dp_cmd_t                   cmd_i,
  output fbik_pkg::dp_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [fbik_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [fbik_pkg::CfgW-1:0]           cfg_data_i,
  input  logic signed [fbik_pkg::CoordW-1:0]  foot_x_i,
  input  logic signed [fbik_pkg::CoordW-1:0]  foot_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                reachable_o,
  output logic signed [fbik_pkg::AngW-1:0]    right_angle_o,
  output logic signed [fbik_pkg::AngW-1:0]    left_angle_o
);
  import fbik_pkg::*;

  logic [CfgW-1:0]            base_q, up_q, lo_q;
  logic signed [AngW-1:0]     held_r_q, held_l_q;
  logic                       out_valid_q;
  logic                       out_reach_q;
  logic signed [AngW-1:0]     out_r_q, out_l_q;

  logic signed [CoordW-1:0]   fx_q, fy_q;
  logic signed [OffW-1:0]     ox_q;
  logic signed [CoordW-1:0]   oy_q;
  logic signed [ProdW-1:0]    prod_q;
  logic [MulW-1:0]            d2_q;
  logic [29:0]                up2_q, lo2_q;
  logic [31:0]                sum2_q;
  logic signed [MulW-1:0]     lead_q;
  logic [RootW-1:0]           span_q, rad_q;
  logic signed [KneeW-1:0]    pa_q, u1_q, u2_q, v1_q, v2_q;
  logic signed [KneeW-1:0]    kru_q, krv_q, klu_q, klv_q;
  logic                       reach_q;

  logic signed [MulW-1:0]     ma, mb;
  logic                       is_mul;
  logic [CfgW:0]              link_sum;
  logic [CfgW-1:0]            link_gap;
  logic [31:0]                gap2;
  logic                       unreach;
  logic [RootW-1:0]           sq;
  logic signed [KneeW-1:0]    p52;
  logic                       pick_first;
  logic [HgtW-1:0]            hgt;
  logic                       sqrt_done;
  logic signed [ZW-1:0]       z;
  logic                       atan_done;
  logic signed [AngWideW-1:0] zx, ang_w;

  assign link_sum = {1'b0, up_q} + {1'b0, lo_q};
  assign link_gap = (up_q > lo_q) ? (up_q - lo_q) : (lo_q - up_q);
  assign gap2     = prod_q[31:0];
  assign unreach  = (d2_q == '0) || (d2_q > {2'b00, sum2_q}) || (d2_q < {2'b00, gap2});
  assign sq       = prod_q[RootW-1:0];
  assign p52      = $signed(prod_q[KneeW-1:0]);
  assign pick_first = cmd_i.left ? (u1_q < u2_q) : (u1_q > u2_q);

  // operand select of the shared multiplier
  always_comb begin
    ma     = '0;
    mb     = '0;
    is_mul = 1'b1;
    case (cmd_i.op)
      OP_MUL_OXOX:   begin ma = MulW'(ox_q);     mb = MulW'(ox_q);     end
      OP_MUL_OYOY:   begin ma = MulW'(oy_q);     mb = MulW'(oy_q);     end
      OP_MUL_UPUP:   begin ma = MulW'(up_q);     mb = MulW'(up_q);     end
      OP_MUL_LOLO:   begin ma = MulW'(lo_q);     mb = MulW'(lo_q);     end
      OP_MUL_SUM:    begin ma = MulW'(link_sum); mb = MulW'(link_sum); end
      OP_MUL_GAP:    begin ma = MulW'(link_gap); mb = MulW'(link_gap); end
      OP_MUL_SPAN:   begin ma = $signed(d2_q);   mb = MulW'(up2_q);    end
      OP_MUL_LEAD2:  begin ma = lead_q;          mb = lead_q;          end
      OP_MUL_LEADOX: begin ma = lead_q;          mb = MulW'(ox_q);     end
      OP_MUL_HOY:    begin ma = MulW'(hgt);      mb = MulW'(oy_q);     end
      OP_MUL_LEADOY: begin ma = lead_q;          mb = MulW'(oy_q);     end
      OP_MUL_HOX:    begin ma = MulW'(hgt);      mb = MulW'(ox_q);     end
      default:       is_mul = 1'b0;
    endcase
  end

  fbik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT_START),
    .rad_i   (rad_q),
    .root_o  (hgt),
    .done_o  (sqrt_done)
  );

  fbik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_ATAN_START),
    .x_i     (cmd_i.left ? klu_q : kru_q),
    .y_i     (cmd_i.left ? klv_q : krv_q),
    .z_o     (z),
    .done_o  (atan_done)
  );

  // right motor is -atan2, left motor is -(atan2 + pi)
  assign zx    = AngWideW'(z);
  assign ang_w = cmd_i.left ? -(zx + AngWideW'(PiWork)) : -zx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 15'd2765;
      up_q        <= 15'd2560;
      lo_q        <= 15'd5120;
      held_r_q    <= '0;
      held_l_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_BASE:  base_q <= cfg_data_i;
          REG_UPPER: up_q   <= cfg_data_i;
          REG_LOWER: lo_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ANG_STORE) begin
        if (cmd_i.left) held_l_q <= to_angle(ang_w);
        else            held_r_q <= to_angle(ang_w);
      end
      if (cmd_i.op == OP_OUT_LOAD) out_valid_q <= 1'b1;
      else if (out_ready_i)        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_mul) prod_q <= ma * mb;
    case (cmd_i.op)
      OP_LOAD_IN: begin
        fx_q <= foot_x_i;
        fy_q <= foot_y_i;
      end
      OP_OFFSET: begin
        ox_q <= OffW'(fx_q) - (cmd_i.left ? OffW'(0) : $signed({3'b000, base_q}));
        oy_q <= fy_q;
      end
      OP_D2_LOAD:   d2_q   <= prod_q[MulW-1:0];
      OP_D2_ADD:    d2_q   <= d2_q + prod_q[MulW-1:0];
      OP_UP2_LOAD:  up2_q  <= prod_q[29:0];
      OP_LO2_LOAD:  lo2_q  <= prod_q[29:0];
      OP_SUM2_LOAD: sum2_q <= prod_q[31:0];
      OP_CHECK: begin
        reach_q <= !unreach;
        lead_q  <= $signed({4'b0000, up2_q}) - $signed({4'b0000, lo2_q}) + $signed(d2_q);
      end
      OP_SPAN_LOAD: span_q <= {prod_q[RootW-3:0], 2'b00};
      OP_RAD:       rad_q  <= (span_q > sq) ? (span_q - sq) : '0;
      OP_PA_LOAD:   pa_q   <= p52;
      OP_U_SET: begin
        u1_q <= pa_q - p52;
        u2_q <= pa_q + p52;
      end
      OP_V_SET: begin
        v1_q <= pa_q + p52;
        v2_q <= pa_q - p52;
      end
      OP_PICK: begin
        if (cmd_i.left) begin
          klu_q <= pick_first ? u1_q : u2_q;
          klv_q <= pick_first ? v1_q : v2_q;
        end else begin
          kru_q <= pick_first ? u1_q : u2_q;
          krv_q <= pick_first ? v1_q : v2_q;
        end
      end
      OP_OUT_LOAD: begin
        out_reach_q <= reach_q;
        out_r_q     <= held_r_q;
        out_l_q     <= held_l_q;
      end
      default: ;
    endcase
  end

  assign sts_o.reach     = reach_q;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.atan_done = atan_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign reachable_o   = out_reach_q;
  assign right_angle_o = out_r_q;
  assign left_angle_o  = out_l_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_OUT_LOAD |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  a_store_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_ANG_STORE |-> reach_q)
    else $error("angles updated for unreachable foot");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> ({32'd0, hgt} * {32'd0, hgt} <= rad_q))
    else $error("square root too large");

endmodule

/* hdl/fbik_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_ctrl
// Sequencer: walks the knee micro-op steps for both pivots, waits on the root
// and atan units and hands the result to the output register.
// ----------------------------------------------------------------------------
module fbik_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output fbik_pkg::dp_cmd_t   cmd_o,
  input  fbik_pkg::dp_sts_t   sts_i
);
  import fbik_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_KNEE_A    = 7'b0000010,
    ST_SQRT_WAIT = 7'b0000100,
    ST_KNEE_B    = 7'b0001000,
    ST_ATAN_GO   = 7'b0010000,
    ST_ATAN_WAIT = 7'b0100000,
    ST_OUT       = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             left_q, left_d;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    left_d    = left_q;
    cmd_o.op  = OP_NOP;
    cmd_o.left = left_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD_IN;
          left_d   = 1'b0;
          step_d   = '0;
          state_d  = ST_KNEE_A;
        end
      end
      ST_KNEE_A: begin
        if (step_q == StepSpan && !sts_i.reach) begin
          // foot out of reach of this pivot
          state_d = ST_OUT;
        end else begin
          cmd_o.op = knee_op(step_q);
          step_d   = step_q + StepW'(1);
          if (step_q == StepSqrt) state_d = ST_SQRT_WAIT;
        end
      end
      ST_SQRT_WAIT: begin
        if (sts_i.sqrt_done) state_d = ST_KNEE_B;
      end
      ST_KNEE_B: begin
        cmd_o.op = knee_op(step_q);
        step_d   = step_q + StepW'(1);
        if (step_q == StepLast) begin
          step_d = '0;
          if (!left_q) begin
            left_d  = 1'b1;
            state_d = ST_KNEE_A;
          end else begin
            left_d  = 1'b0;
            state_d = ST_ATAN_GO;
          end
        end
      end
      ST_ATAN_GO: begin
        cmd_o.op = OP_ATAN_START;
        state_d  = ST_ATAN_WAIT;
      end
      ST_ATAN_WAIT: begin
        if (sts_i.atan_done) begin
          cmd_o.op = OP_ANG_STORE;
          if (left_q) begin
            state_d = ST_OUT;
          end else begin
            left_d  = 1'b1;
            state_d = ST_ATAN_GO;
          end
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_OUT_LOAD;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      left_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      left_q  <= left_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_SQRT_START |=> state_q == ST_SQRT_WAIT)
    else $error("no wait after root start");

  a_knee_b_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KNEE_B |-> step_q > StepSqrt)
    else $error("second knee phase on early step");

  a_out_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !sts_i.out_busy) |=> state_q == ST_IDLE)
    else $error("result not handed off");

endmodule
